[sv/tda_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Track distance accumulator package
// Shared types and constants for the front end, back end and top level.
// ----------------------------------------------------------------------------
package tda_pkg;

    // Fix tags.
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_DATA   = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    localparam int SUM_BITS  = 48;
    localparam int DIST_BITS = 25;
    localparam int OUT_COORD = 24;
    localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // Back end sequencer states.
    typedef enum logic [2:0] {
        BE_IDLE,
        BE_ROOT1,
        BE_ROOT2,
        BE_DIV,
        BE_OUT
    } be_state_t;

endpackage : tda_pkg
`default_nettype wire

[sv/tda_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Track distance front end
// Accepts fixes, drops unused tags and fixes while idle, and queues the stop
// flag, coordinate differences and final coordinates of each counted fix.
// ----------------------------------------------------------------------------
module tda_front
    import tda_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_mode,
    input  wire logic [COORD_BITS-1:0] s_x,
    input  wire logic [COORD_BITS-1:0] s_y,
    output logic                       q_push,
    output logic [4*(COORD_BITS+1)+1+2*OUT_COORD-1:0] q_data,
    input  wire logic                  q_full
);

    localparam int DW = COORD_BITS + 1;

    logic                  tracking_reg;
    logic [COORD_BITS-1:0] start_x_reg, start_y_reg, prev_x_reg, prev_y_reg;
    logic                  accept;
    logic                  counted;
    logic                  is_start;
    logic                  is_stop;
    logic signed [DW-1:0]  dpx, dpy, dsx, dsy;
    logic [OUT_COORD-1:0]  fx, fy;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_start = (s_mode == MODE_START);
    assign is_stop  = (s_mode == MODE_STOP);
    assign counted  = accept && tracking_reg &&
                      ((s_mode == MODE_DATA) || (s_mode == MODE_STOP));

    // Differences one bit wider than the coordinates never overflow.
    assign dpx = $signed({s_x[COORD_BITS-1], s_x}) -
                 $signed({prev_x_reg[COORD_BITS-1], prev_x_reg});
    assign dpy = $signed({s_y[COORD_BITS-1], s_y}) -
                 $signed({prev_y_reg[COORD_BITS-1], prev_y_reg});
    assign dsx = $signed({s_x[COORD_BITS-1], s_x}) -
                 $signed({start_x_reg[COORD_BITS-1], start_x_reg});
    assign dsy = $signed({s_y[COORD_BITS-1], s_y}) -
                 $signed({start_y_reg[COORD_BITS-1], start_y_reg});

    // Final coordinates as 24-bit output words.
    generate
        if (COORD_BITS >= OUT_COORD) begin : g_trunc
            assign fx = s_x[OUT_COORD-1:0];
            assign fy = s_y[OUT_COORD-1:0];
        end else begin : g_ext
            assign fx = {{(OUT_COORD-COORD_BITS){s_x[COORD_BITS-1]}}, s_x};
            assign fy = {{(OUT_COORD-COORD_BITS){s_y[COORD_BITS-1]}}, s_y};
        end
    endgenerate

    assign q_push = counted;
    assign q_data = {is_stop, dpx, dpy, dsx, dsy, fx, fy};

    // Track state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracking_reg <= 1'b0;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
        end else if (accept && is_start) begin
            tracking_reg <= 1'b1;
            start_x_reg  <= s_x;
            start_y_reg  <= s_y;
            prev_x_reg   <= s_x;
            prev_y_reg   <= s_y;
        end else if (counted) begin
            prev_x_reg <= s_x;
            prev_y_reg <= s_y;
            if (is_stop) begin
                tracking_reg <= 1'b0;
            end
        end
    end

endmodule : tda_front
`default_nettype wire

[sv/tda_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Track distance work queue
// Small FIFO between the front end and the back end. Only counted fixes are
// queued; a start fix waits until the queue and the back end have drained.
// ----------------------------------------------------------------------------
module tda_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH_LOG = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);

    localparam int DEPTH = 1 << DEPTH_LOG;

    logic [WIDTH-1:0]     mem [DEPTH];
    logic [DEPTH_LOG-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [DEPTH_LOG:0]   count_reg;

    assign full      = (count_reg == (DEPTH_LOG+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && not_empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && not_empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule : tda_queue
`default_nettype wire

[sv/tda_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Track distance back end
// Takes queued fixes, works the two floor square roots one bit a cycle,
// keeps the saturating sums and count, and divides for the average on stop.
// ----------------------------------------------------------------------------
module tda_back
    import tda_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter longint unsigned MAX_FIXES = 65535
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      clear,
    input  wire logic                      q_valid,
    input  wire logic [4*(COORD_BITS+1)+1+2*OUT_COORD-1:0] q_data,
    output logic                           q_pop,
    output logic                           busy,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [OUT_COORD-1:0]           m_final_x,
    output logic [OUT_COORD-1:0]           m_final_y,
    output logic [SUM_BITS-1:0]            m_total_distance,
    output logic [DIST_BITS-1:0]           m_distance_to_start,
    output logic [DIST_BITS-1:0]           m_average_to_start
);

    localparam int DW    = COORD_BITS + 1;
    localparam int SQW   = 2 * DW + 1;                  // sum of two squares
    localparam int RW    = (SQW + 1) / 2;               // root width
    localparam int RADW  = 2 * RW;                      // whole bit pairs
    localparam int ITER  = RW;
    localparam int IW    = $clog2(ITER + 1);
    localparam int CNTW  = $clog2(MAX_FIXES + 1);
    localparam int DIVI  = SUM_BITS;
    localparam int DIVW  = $clog2(DIVI + 1);
    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_FIXES);

    be_state_t state_reg, state_next;

    logic                 stop_reg;
    logic [OUT_COORD-1:0] fx_reg, fy_reg;
    logic [DW-1:0]        dsx_reg, dsy_reg;
    logic [2*DW-1:0]      sq_a_reg, sq_b_reg;
    logic                 sq_go_reg;

    // Root unit.
    logic [RADW-1:0]      rad_reg;
    logic [RW+1:0]        rem_reg;
    logic [RW-1:0]        root_reg;
    logic [IW-1:0]        iter_reg;
    logic [RW+1:0]        rem_sh, trial;

    logic [SUM_BITS-1:0]  path_sum_reg, sdist_sum_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [RW-1:0]        dstart_reg;

    // Divider.
    logic [SUM_BITS-1:0]  quo_reg;
    logic [CNTW:0]        drem_reg;
    logic [DIVW-1:0]      div_i_reg;
    logic [CNTW:0]        drem_sh;

    logic                 out_valid_reg;
    logic                 root_done;

    logic [DW-1:0]        dpx, dpy, dsx, dsy;
    logic [DW-1:0]        apx, apy;
    logic [SUM_BITS:0]    psum_w, ssum_w;

    assign {dpx, dpy, dsx, dsy} = q_data[4*DW+2*OUT_COORD-1:2*OUT_COORD];

    function automatic logic [DW-1:0] absval(input logic [DW-1:0] v);
        absval = v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    assign apx = absval(dpx);
    assign apy = absval(dpy);

    assign q_pop     = (state_reg == BE_IDLE) && q_valid && !clear && !sq_go_reg;
    assign root_done = (iter_reg == '0);

    // Busy from the pop until the roots end, or until a stop result is taken.
    assign busy = (state_reg != BE_IDLE) || sq_go_reg || out_valid_reg;

    assign rem_sh = {rem_reg[RW-1:0], rad_reg[RADW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign drem_sh = {drem_reg[CNTW-1:0], quo_reg[SUM_BITS-1]};

    assign psum_w = {1'b0, path_sum_reg} + (SUM_BITS+1)'(root_reg);
    assign ssum_w = {1'b0, sdist_sum_reg} + (SUM_BITS+1)'(root_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE:  if (sq_go_reg) state_next = BE_ROOT1;
            BE_ROOT1: if (root_done) state_next = BE_ROOT2;
            BE_ROOT2: if (root_done) state_next = stop_reg ? BE_DIV : BE_IDLE;
            BE_DIV:   if (div_i_reg == '0) state_next = BE_OUT;
            BE_OUT:   if (!out_valid_reg) state_next = BE_IDLE;
            default:  state_next = BE_IDLE;
        endcase
        if (clear) state_next = BE_IDLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath: root iterations, sums and division.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_go_reg     <= 1'b0;
            path_sum_reg  <= '0;
            sdist_sum_reg <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            div_i_reg     <= '0;
        end else if (clear) begin
            sq_go_reg     <= 1'b0;
            path_sum_reg  <= '0;
            sdist_sum_reg <= '0;
            cnt_reg       <= '0;
        end else begin
            sq_go_reg <= 1'b0;
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                stop_reg  <= q_data[4*DW+2*OUT_COORD];
                fx_reg    <= q_data[2*OUT_COORD-1:OUT_COORD];
                fy_reg    <= q_data[OUT_COORD-1:0];
                dsx_reg   <= absval(dsx);
                dsy_reg   <= absval(dsy);
                sq_go_reg <= 1'b1;
                if (cnt_reg != CNT_MAX) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            case (state_reg)
                BE_IDLE: begin
                    if (sq_go_reg) begin
                        rad_reg  <= RADW'(sq_a_reg) + RADW'(sq_b_reg);
                        rem_reg  <= '0;
                        root_reg <= '0;
                        iter_reg <= IW'(ITER);
                    end
                end
                BE_ROOT1, BE_ROOT2: begin
                    if (!root_done) begin
                        rad_reg  <= rad_reg << 2;
                        iter_reg <= iter_reg - 1'b1;
                        if (rem_sh >= trial) begin
                            rem_reg  <= rem_sh - trial;
                            root_reg <= {root_reg[RW-2:0], 1'b1};
                        end else begin
                            rem_reg  <= rem_sh;
                            root_reg <= {root_reg[RW-2:0], 1'b0};
                        end
                    end else if (state_reg == BE_ROOT1) begin
                        path_sum_reg <= psum_w[SUM_BITS] ? SUM_MAX : psum_w[SUM_BITS-1:0];
                        rad_reg  <= RADW'(sq_a_reg) + RADW'(sq_b_reg);
                        rem_reg  <= '0;
                        root_reg <= '0;
                        iter_reg <= IW'(ITER);
                    end else begin
                        sdist_sum_reg <= ssum_w[SUM_BITS] ? SUM_MAX : ssum_w[SUM_BITS-1:0];
                        dstart_reg    <= root_reg;
                        quo_reg       <= ssum_w[SUM_BITS] ? SUM_MAX : ssum_w[SUM_BITS-1:0];
                        drem_reg      <= '0;
                        div_i_reg     <= DIVW'(DIVI);
                    end
                end
                BE_DIV: begin
                    if (div_i_reg != '0) begin
                        div_i_reg <= div_i_reg - 1'b1;
                        if (drem_sh >= {1'b0, cnt_reg}) begin
                            drem_reg <= drem_sh - {1'b0, cnt_reg};
                            quo_reg  <= {quo_reg[SUM_BITS-2:0], 1'b1};
                        end else begin
                            drem_reg <= drem_sh;
                            quo_reg  <= {quo_reg[SUM_BITS-2:0], 1'b0};
                        end
                    end else begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Squarers: first pass squares the step, second the distance to start.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            sq_a_reg <= apx * apx;
            sq_b_reg <= apy * apy;
        end else if (state_reg == BE_ROOT1) begin
            sq_a_reg <= dsx_reg * dsx_reg;
            sq_b_reg <= dsy_reg * dsy_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_final_x        = fx_reg;
    assign m_final_y        = fy_reg;
    assign m_total_distance = path_sum_reg;
    assign m_distance_to_start =
        (RW > DIST_BITS && (dstart_reg >> DIST_BITS) != '0) ? DIST_MAX : DIST_BITS'(dstart_reg);
    assign m_average_to_start =
        ((quo_reg >> DIST_BITS) != '0) ? DIST_MAX : quo_reg[DIST_BITS-1:0];

endmodule : tda_back
`default_nettype wire

[sv/track_distance_accumulator_top.sv]
`default_nettype none
// A counted fix passes the back end as two bit-serial floor square roots on the
// shared root unit; a stop fix adds the bit-serial division, then waits for
// m_ready. The back end takes no new fix until it is done with the last one;
// other fixes need no back end work, but a start fix waits until all work has
// drained.
// Reset is synchronous, active low, and clears the track, sums, count and queue.
// ----------------------------------------------------------------------------
// Track distance accumulator top level
// Front end classifies fixes, a queue decouples it from the arithmetic back end.
// ----------------------------------------------------------------------------
module track_distance_accumulator_top
    import tda_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter longint unsigned MAX_FIXES = 65535
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_mode,
    input  wire logic [COORD_BITS-1:0] s_pos_x,
    input  wire logic [COORD_BITS-1:0] s_pos_y,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [OUT_COORD-1:0]       m_final_x,
    output logic [OUT_COORD-1:0]       m_final_y,
    output logic [SUM_BITS-1:0]        m_total_distance,
    output logic [DIST_BITS-1:0]       m_distance_to_start,
    output logic [DIST_BITS-1:0]       m_average_to_start
);

    localparam int QW = 4 * (COORD_BITS + 1) + 1 + 2 * OUT_COORD;

    logic          q_push, q_full, q_pop, q_nempty, fe_ready, busy, back_busy, clear;
    logic [QW-1:0] q_in, q_out;

    // A start fix waits until the back end and queue are drained, then clears.
    assign busy    = q_nempty || back_busy;
    assign s_ready = fe_ready && !((s_mode == MODE_START) && busy);
    assign clear   = s_valid && s_ready && (s_mode == MODE_START);

    tda_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid && s_ready), .s_ready(fe_ready),
        .s_mode(s_mode), .s_x(s_pos_x), .s_y(s_pos_y),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    tda_queue #(.WIDTH(QW), .DEPTH_LOG(2)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .not_empty(q_nempty)
    );

    tda_back #(.COORD_BITS(COORD_BITS), .MAX_FIXES(MAX_FIXES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .clear(clear),
        .q_valid(q_nempty), .q_data(q_out), .q_pop(q_pop), .busy(back_busy),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_final_x(m_final_x), .m_final_y(m_final_y),
        .m_total_distance(m_total_distance),
        .m_distance_to_start(m_distance_to_start),
        .m_average_to_start(m_average_to_start)
    );

`ifndef SYNTHESIS
    // A held result stays valid, with a stable total distance, until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_distance))
        else $error("result changed while stalled");
    // A start fix is never taken while work is outstanding.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |-> !q_nempty && !m_valid)
        else $error("start taken while busy");
`endif

endmodule : track_distance_accumulator_top
`default_nettype wire

[sim/track_distance_accumulator_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track distance accumulator testbench
// Drives tagged position fixes through a valid/ready driver and checks each
// trip result against a cycle-free predictor of every result field.
// ----------------------------------------------------------------------------
module track_distance_accumulator_top_test
    import tda_pkg::*;
;

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] x;
        logic [23:0] y;
    } fix_t;

    typedef struct packed {
        logic [23:0] fx;
        logic [23:0] fy;
        logic [47:0] total;
        logic [24:0] dstart;
        logic [24:0] avg;
    } trip_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_mode = 2'd0;
    logic [23:0] s_pos_x = '0;
    logic [23:0] s_pos_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [23:0] m_final_x, m_final_y;
    logic [47:0] m_total_distance;
    logic [24:0] m_distance_to_start, m_average_to_start;

    track_distance_accumulator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_final_x(m_final_x), .m_final_y(m_final_y),
        .m_total_distance(m_total_distance),
        .m_distance_to_start(m_distance_to_start),
        .m_average_to_start(m_average_to_start)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    fix_t pending_fixes[$];
    trip_t expected_trips[$];
    int errors = 0;
    bit stim_done = 1'b0;
    bit quiet = 1'b0;
    bit in_taken = 1'b0;
    int unsigned cycles = 0;

    // Predictor state.
    bit trk = 1'b0;
    logic signed [23:0] sx = 0, sy = 0, px = 0, py = 0;
    logic [47:0] path_total = 0, start_total = 0;
    logic [15:0] counted = 0;

    // Floor square root of dx^2 + dy^2, exact on 64-bit squares.
    function automatic logic [63:0] step_length(longint dx, longint dy);
        logic [67:0] acc;
        logic [67:0] r;
        logic [67:0] b;
        acc = 68'(dx * dx) + 68'(dy * dy);
        r = 0;
        b = 68'd1 << 66;
        while (b > acc) b = b >> 2;
        while (b != 0) begin
            if (acc >= r + b) begin
                acc = acc - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[63:0];
    endfunction

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {17'd0, a} + {1'b0, b};
        return (s > 65'(SUM_MAX)) ? SUM_MAX : s[47:0];
    endfunction

    function automatic logic [24:0] clip25(logic [63:0] v);
        return (v > 64'(DIST_MAX)) ? DIST_MAX : v[24:0];
    endfunction

    // Apply one accepted fix to the predictor.
    task automatic track_fix(fix_t f);
        logic signed [23:0] x, y;
        logic [63:0] ds, mean;
        trip_t t;
        x = f.x;
        y = f.y;
        if (f.mode == MODE_START) begin
            trk = 1'b1;
            sx = x; px = x; sy = y; py = y;
            path_total = 0; start_total = 0; counted = 0;
        end else if (f.mode != MODE_UNUSED && trk) begin
            path_total = add_sat(path_total,
                step_length(longint'(x) - longint'(px), longint'(y) - longint'(py)));
            ds = step_length(longint'(x) - longint'(sx), longint'(y) - longint'(sy));
            start_total = add_sat(start_total, ds);
            if (counted != 16'hFFFF) counted = counted + 16'd1;
            px = x; py = y;
            if (f.mode == MODE_STOP) begin
                trk = 1'b0;
                mean = (counted != 0) ? 64'(start_total) / 64'(counted) : 0;
                t.fx = x; t.fy = y; t.total = path_total;
                t.dstart = clip25(ds); t.avg = clip25(mean);
                expected_trips.push_back(t);
            end
        end
    endtask

    // Driver: inputs change on the falling edge; acceptance comes from the rising edge.
    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                track_fix(pending_fixes.pop_front());
                if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
            end
            if (s_valid && !in_taken) begin
                // hold the item
            end else if (send_gap > 0 || pending_fixes.size() == 0) begin
                if (send_gap > 0) send_gap = send_gap - 1;
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_mode <= pending_fixes[0].mode;
                s_pos_x <= pending_fixes[0].x;
                s_pos_y <= pending_fixes[0].y;
            end
        end
    end

    // Receiver stall generator.
    int recv_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: handshakes and outputs sampled at the rising edge.
    always @(posedge aclk) begin
        trip_t e;
        cycles <= cycles + 1;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_trips.size() == 0) begin
                $error("unexpected result item");
                errors = errors + 1;
            end else begin
                e = expected_trips.pop_front();
                if (m_final_x !== e.fx) begin
                    $error("final_x expected %h actual %h", e.fx, m_final_x);
                    errors = errors + 1;
                end
                if (m_final_y !== e.fy) begin
                    $error("final_y expected %h actual %h", e.fy, m_final_y);
                    errors = errors + 1;
                end
                if (m_total_distance !== e.total) begin
                    $error("total_distance expected %h actual %h", e.total,
                           m_total_distance);
                    errors = errors + 1;
                end
                if (m_distance_to_start !== e.dstart) begin
                    $error("distance_to_start expected %h actual %h", e.dstart,
                           m_distance_to_start);
                    errors = errors + 1;
                end
                if (m_average_to_start !== e.avg) begin
                    $error("average_to_start expected %h actual %h", e.avg,
                           m_average_to_start);
                    errors = errors + 1;
                end
            end
        end
    end

    function automatic logic [23:0] rand_coord(int kind);
        case (kind)
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(int'($urandom_range(0, 8191)) - 4096);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_fix(logic [1:0] m, logic [23:0] x, logic [23:0] y);
        fix_t f;
        f.mode = m; f.x = x; f.y = y;
        pending_fixes.push_back(f);
    endtask

    initial begin
        int n, len, k;
        // Directed: idle fixes, unused mode, extremes and a restart.
        add_fix(MODE_DATA, 24'h000100, 24'h000100);
        add_fix(MODE_STOP, 24'h000200, 24'h000000);
        add_fix(MODE_UNUSED, 24'h123456, 24'h654321);
        add_fix(MODE_START, 24'h800000, 24'h800000);
        add_fix(MODE_DATA, 24'h7FFFFF, 24'h7FFFFF);
        add_fix(MODE_UNUSED, 24'h000000, 24'h000000);
        add_fix(MODE_STOP, 24'h7FFFFF, 24'h800000);
        add_fix(MODE_START, 24'h000000, 24'h000000);
        add_fix(MODE_DATA, 24'h000300, 24'h000400);
        add_fix(MODE_START, 24'h000100, 24'hFFFF00);
        add_fix(MODE_DATA, 24'h000100, 24'hFFFF00);
        add_fix(MODE_STOP, 24'hFFFFFF, 24'h000000);
        add_fix(MODE_START, 24'h7FFFFF, 24'h7FFFFF);
        add_fix(MODE_STOP, 24'h7FFFFF, 24'h7FFFFF);
        add_fix(MODE_START, 24'h800000, 24'h7FFFFF);
        add_fix(MODE_STOP, 24'h7FFFFF, 24'h800000);
        // Random tracks, mostly well formed, some noise.
        n = 0;
        while (n < 1650) begin
            if ($urandom_range(0, 9) == 0) begin
                add_fix(2'($urandom), rand_coord($urandom_range(0, 3)),
                        rand_coord($urandom_range(0, 3)));
                n = n + 1;
            end else begin
                k = $urandom_range(0, 3);
                len = $urandom_range(0, 12);
                add_fix(MODE_START, rand_coord(k), rand_coord($urandom_range(0, 3)));
                repeat (len) add_fix(MODE_DATA, rand_coord(k), rand_coord(k));
                add_fix(MODE_STOP, rand_coord(k), rand_coord(k));
                n = n + len + 2;
            end
            if (n > 1400) quiet = 1'b1;
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_done && pending_fixes.size() == 0 && !s_valid
              && expected_trips.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("track_distance_accumulator_top_test passed");
        end else begin
            $display("track_distance_accumulator_top_test failed");
        end
        $finish;
    end

    // Watchdog on the cycle count.
    always @(posedge aclk) begin
        if (cycles > 2000000) begin
            $display("track_distance_accumulator_top_test failed");
            $finish;
        end
    end
endmodule

[files.f]
sv/tda_pkg.sv
sv/tda_front.sv
sv/tda_queue.sv
sv/tda_back.sv
sv/track_distance_accumulator_top.sv
sim/track_distance_accumulator_top_test.sv
